FILE: sv/tcw_pkg.sv
// Shared constants, command codes and result type of the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CURSOR_COL_W = 7;
  localparam int CURSOR_ROW_W = 5;

  localparam logic [7:0] CH_NEWLINE        = 8'd10;
  localparam logic [7:0] CH_RETURN         = 8'd13;
  localparam logic [7:0] CH_SPACE          = 8'd32;
  localparam logic [7:0] BLANK_COLOR_RESET = 8'd7;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0]              cell_char;
    logic [7:0]              cell_color;
    logic [CURSOR_COL_W-1:0] cursor_col;
    logic [CURSOR_ROW_W-1:0] cursor_row;
  } res_t;

endpackage

FILE: sv/tcw_intf.sv
// Handshake channel interfaces for requests, results and configuration writes.
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [7:0] char_color;
  logic [7:0] col;
  logic [7:0] row;

  modport source (output valid, command, char_code, char_color, col, row, input ready);
  modport sink   (input valid, command, char_code, char_color, col, row, output ready);
endinterface

interface tcw_out_if;
  logic                              valid;
  logic                              ready;
  logic [7:0]                        cell_char;
  logic [7:0]                        cell_color;
  logic [tcw_pkg::CURSOR_COL_W-1:0]  cursor_col;
  logic [tcw_pkg::CURSOR_ROW_W-1:0]  cursor_row;

  modport source (output valid, cell_char, cell_color, cursor_col, cursor_row, input ready);
  modport sink   (input valid, cell_char, cell_color, cursor_col, cursor_row, output ready);
endinterface

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: sv/tcw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tcw_ctrl.sv
// Command sequencer: cursor, scroll origin and read-modify-write access to the screen RAM.
module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  tcw_in_if.sink        in_ch,
  input  logic [7:0]    blank_color,
  output logic          res_valid,
  input  logic          res_ready,
  output tcw_pkg::res_t res
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  typedef enum logic [2:0] {
    S_IDLE, S_PROW, S_ADDR, S_WRITE, S_READ, S_RDATA, S_BLANK, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    K_PUT, K_READ, K_SCROLL
  } kind_t;

  // Control state.
  state_t           state_r, state_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    last_r, last_nxt;
  logic [7:0]       sweep_color_r, sweep_color_nxt;
  logic             respond_r, respond_nxt;

  // Datapath registers.
  kind_t            kind_r, kind_nxt;
  logic [ROW_W-1:0] rowsel_r, rowsel_nxt;
  logic [COL_W-1:0] colsel_r, colsel_nxt;
  logic [ROW_W-1:0] prow_r, prow_nxt;
  logic [7:0]       chr_r, chr_nxt;
  logic [7:0]       clr_r, clr_nxt;
  logic [7:0]       rchar_r, rchar_nxt;
  logic [7:0]       rcolor_r, rcolor_nxt;

  logic             in_fire;
  logic             in_range;
  logic             col_last;
  logic             row_last;
  logic [ROW_W-1:0] top_inc;
  logic [ROW_W:0]   psum;
  logic [AW-1:0]    base;
  logic [7:0]       col_ext;
  logic [7:0]       row_ext;

  logic             ram_we;
  logic [15:0]      ram_wdata;
  logic             ram_re;
  logic [15:0]      ram_rdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = (in_ch.col < 8'(COLUMNS)) && (in_ch.row < 8'(ROWS));
  assign col_last    = (cur_col_r == COL_W'(COLUMNS - 1));
  assign row_last    = (cur_row_r == ROW_W'(ROWS - 1));
  assign top_inc     = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;

  // Logical row plus scroll origin, folded back into the physical row range.
  assign psum = {1'b0, rowsel_r} + {1'b0, top_r};
  assign base = AW'(prow_r) * AW'(COLUMNS);

  always_comb begin
    state_nxt       = state_r;
    cur_col_nxt     = cur_col_r;
    cur_row_nxt     = cur_row_r;
    top_nxt         = top_r;
    addr_nxt        = addr_r;
    last_nxt        = last_r;
    sweep_color_nxt = sweep_color_r;
    respond_nxt     = respond_r;
    kind_nxt        = kind_r;
    rowsel_nxt      = rowsel_r;
    colsel_nxt      = colsel_r;
    prow_nxt        = prow_r;
    chr_nxt         = chr_r;
    clr_nxt         = clr_r;
    rchar_nxt       = rchar_r;
    rcolor_nxt      = rcolor_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rchar_nxt  = '0;
          rcolor_nxt = '0;
          unique case (tcw_pkg::cmd_t'(in_ch.command))
            tcw_pkg::CMD_PUT: begin
              priority if (in_ch.char_code == tcw_pkg::CH_NEWLINE) begin
                cur_col_nxt = '0;
                if (row_last) begin
                  // Scroll: the old top row becomes the blank bottom row.
                  prow_nxt   = top_r;
                  top_nxt    = top_inc;
                  colsel_nxt = '0;
                  kind_nxt   = K_SCROLL;
                  state_nxt  = S_ADDR;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                  state_nxt   = S_DONE;
                end
              end else if (in_ch.char_code == tcw_pkg::CH_RETURN) begin
                cur_col_nxt = '0;
                state_nxt   = S_DONE;
              end else begin
                rowsel_nxt = cur_row_r;
                colsel_nxt = cur_col_r;
                chr_nxt    = in_ch.char_code;
                clr_nxt    = in_ch.char_color;
                kind_nxt   = K_PUT;
                state_nxt  = S_PROW;
              end
            end
            tcw_pkg::CMD_SET: begin
              if (in_range) begin
                cur_col_nxt = COL_W'(in_ch.col);
                cur_row_nxt = ROW_W'(in_ch.row);
              end
              state_nxt = S_DONE;
            end
            tcw_pkg::CMD_CLEAR: begin
              cur_col_nxt     = '0;
              cur_row_nxt     = '0;
              top_nxt         = '0;
              addr_nxt        = '0;
              last_nxt        = AW'(DEPTH - 1);
              sweep_color_nxt = blank_color;
              respond_nxt     = 1'b1;
              state_nxt       = S_BLANK;
            end
            tcw_pkg::CMD_READ: begin
              if (in_range) begin
                rowsel_nxt = ROW_W'(in_ch.row);
                colsel_nxt = COL_W'(in_ch.col);
                kind_nxt   = K_READ;
                state_nxt  = S_PROW;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PROW: begin
        if (psum >= (ROW_W + 1)'(ROWS)) begin
          prow_nxt = ROW_W'(psum - (ROW_W + 1)'(ROWS));
        end else begin
          prow_nxt = ROW_W'(psum);
        end
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        addr_nxt = base + AW'(colsel_r);
        last_nxt = base + AW'(COLUMNS - 1);
        unique case (kind_r)
          K_PUT:    state_nxt = S_WRITE;
          K_READ:   state_nxt = S_READ;
          K_SCROLL: begin
            sweep_color_nxt = blank_color;
            respond_nxt     = 1'b1;
            state_nxt       = S_BLANK;
          end
          default:  state_nxt = S_DONE;
        endcase
      end
      S_WRITE: begin
        // The cell is written this cycle; advance the cursor behind it.
        if (col_last) begin
          cur_col_nxt = '0;
          if (row_last) begin
            prow_nxt   = top_r;
            top_nxt    = top_inc;
            colsel_nxt = '0;
            kind_nxt   = K_SCROLL;
            state_nxt  = S_ADDR;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
            state_nxt   = S_DONE;
          end
        end else begin
          cur_col_nxt = cur_col_r + 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_READ: begin
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        rchar_nxt  = ram_rdata[15:8];
        rcolor_nxt = ram_rdata[7:0];
        state_nxt  = S_DONE;
      end
      S_BLANK: begin
        if (addr_r == last_r) begin
          state_nxt = respond_r ? S_DONE : S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // After reset the whole screen is swept to blanks with the reset color.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_BLANK;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      top_r         <= '0;
      addr_r        <= '0;
      last_r        <= AW'(DEPTH - 1);
      sweep_color_r <= tcw_pkg::BLANK_COLOR_RESET;
      respond_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      top_r         <= top_nxt;
      addr_r        <= addr_nxt;
      last_r        <= last_nxt;
      sweep_color_r <= sweep_color_nxt;
      respond_r     <= respond_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    rowsel_r <= rowsel_nxt;
    colsel_r <= colsel_nxt;
    prow_r   <= prow_nxt;
    chr_r    <= chr_nxt;
    clr_r    <= clr_nxt;
    rchar_r  <= rchar_nxt;
    rcolor_r <= rcolor_nxt;
  end

  assign ram_we    = (state_r == S_WRITE) || (state_r == S_BLANK);
  assign ram_wdata = (state_r == S_WRITE) ? {chr_r, clr_r} : {tcw_pkg::CH_SPACE, sweep_color_r};
  assign ram_re    = (state_r == S_READ);

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign col_ext        = 8'(cur_col_r);
  assign row_ext        = 8'(cur_row_r);
  assign res_valid      = (state_r == S_DONE);
  assign res.cell_char  = rchar_r;
  assign res.cell_color = rcolor_r;
  assign res.cursor_col = col_ext[tcw_pkg::CURSOR_COL_W-1:0];
  assign res.cursor_row = row_ext[tcw_pkg::CURSOR_ROW_W-1:0];

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && res_valid))
    else $error("request taken while a result is pending");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r < COL_W'(COLUMNS - 1)) || (cur_col_r == COL_W'(COLUMNS - 1)))
    else $error("cursor column out of range");

  a_origin_range: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r < ROW_W'(ROWS - 1)) || (top_r == ROW_W'(ROWS - 1)))
    else $error("scroll origin out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("sequencer did not leave idle after a request");

  a_write_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (addr_r < AW'(DEPTH)))
    else $error("screen write beyond the last cell");

endmodule

FILE: sv/text_console_writer.sv
// Top level of the text console writer: configuration register, sequencer and result register.
// Each result passes through the output register. A scroll (newline or wrap on the last row)
//   blanks the new bottom row before its result; a clear blanks every cell. One request is handled
//   at a time, paced by the sequencer stepping through the single port pair of the screen RAM.
// After rst_n the sequencer sweeps all ROWS * COLUMNS cells (2000) before it takes a request.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch,
  tcw_cfg_if.sink    cfg_ch
);

  // The blank color is used by clear and scroll; it is always writable.
  logic [7:0] blank_color_r;

  // Result handed from the sequencer to the output register.
  logic          res_valid;
  logic          res_ready;
  tcw_pkg::res_t res;

  // Output register: the sequencer can move on to the next request while the
  // previous result still waits here for the consumer.
  logic          out_valid_r;
  tcw_pkg::res_t out_res_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_color_r <= tcw_pkg::BLANK_COLOR_RESET;
    end else if (cfg_ch.valid) begin
      blank_color_r <= cfg_ch.data;
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .blank_color (blank_color_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // The register can load whenever it is empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_char  = out_res_r.cell_char;
  assign out_ch.cell_color = out_res_r.cell_color;
  assign out_ch.cursor_col = out_res_r.cursor_col;
  assign out_ch.cursor_row = out_res_r.cursor_row;

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("pending result lost or changed before it was taken");

  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid)
    else $error("sequencer dropped a result that the output register refused");

  a_cfg_load: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid |=> (blank_color_r == $past(cfg_ch.data)))
    else $error("configuration write not taken");

endmodule
